// ----- rtl/vpa_pkg.sv -----
// Package for the vector pair angle block: widths, stage counts, beat types, arctangent constants.
package vpa_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int ANGLE_FRAC_DEF  = 13;
    localparam int SAMPLE_BITS_MAX = 24;
    localparam int PROD_W          = 2 * SAMPLE_BITS_MAX;
    localparam int ANGLE_BITS      = 15;
    localparam int ANG_UNIT_BITS   = 48;
    localparam int CORDIC_ITERS    = 40;
    localparam int NORM_BIT        = 40;
    localparam int PRE_MAX         = 2 * SAMPLE_BITS_MAX - 1 - 31;
    localparam int PRE_W           = $clog2(PRE_MAX + 1);
    localparam int SQRT_STEPS      = 32;
    localparam int NORM_STEPS      = 6;
    localparam int FRONT_STAGES    = 7;
    localparam int QUEUE_DEPTH     = 2;
    localparam int LATENCY         = 1 + FRONT_STAGES + SQRT_STEPS + 1 + NORM_STEPS + 1
                                     + CORDIC_ITERS + 1;

    typedef struct packed {
        logic                     nz;
        logic signed [PROD_W-1:0] axbx;
        logic signed [PROD_W-1:0] ayby;
        logic signed [PROD_W-1:0] azbz;
        logic signed [PROD_W-1:0] aybz;
        logic signed [PROD_W-1:0] azby;
        logic signed [PROD_W-1:0] azbx;
        logic signed [PROD_W-1:0] axbz;
        logic signed [PROD_W-1:0] axby;
        logic signed [PROD_W-1:0] aybx;
    } vpa_prod_t;

    localparam int PROD_BEAT_W = $bits(vpa_prod_t);

    typedef struct packed {
        logic full;
        logic empty;
    } vpa_qstat_t;

    function automatic logic [63:0] quarter_pi_q48();
        logic [63:0] t5;
        logic [63:0] s5;
        logic [63:0] t239;
        logic [63:0] s239;
        logic [63:0] part;
        t5   = (64'd1 << ANG_UNIT_BITS) / 64'd5;
        s5   = 64'd0;
        t239 = (64'd1 << ANG_UNIT_BITS) / 64'd239;
        s239 = 64'd0;
        for (int k = 0; k < 32; k++) begin
            if (t5 != 64'd0) begin
                part = t5 / 64'(2 * k + 1);
                s5   = (k % 2 == 0) ? s5 + part : s5 - part;
                t5   = t5 / 64'd25;
            end
            if (t239 != 64'd0) begin
                part = t239 / 64'(2 * k + 1);
                s239 = (k % 2 == 0) ? s239 + part : s239 - part;
                t239 = t239 / 64'd57121;
            end
        end
        return 64'd4 * s5 - s239;
    endfunction

    function automatic logic [63:0] atan_entry(int i);
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] part;
        term = (64'd1 << ANG_UNIT_BITS) >> i;
        sum  = 64'd0;
        if (i == 0) begin
            sum = quarter_pi_q48();
        end
        else begin
            for (int k = 0; k < 25; k++) begin
                if (term != 64'd0) begin
                    part = term / 64'(2 * k + 1);
                    sum  = (k % 2 == 0) ? sum + part : sum - part;
                    term = term >> (2 * i);
                end
            end
        end
        return sum;
    endfunction

    localparam logic [63:0] QUARTER_PI_Q48 = quarter_pi_q48();
    localparam logic [63:0] HALF_PI_Q48    = QUARTER_PI_Q48 << 1;
    localparam logic [63:0] PI_Q48         = QUARTER_PI_Q48 << 2;

endpackage

// ----- rtl/vpa_front.sv -----
// Front part: sign-extend samples, flag zero vectors, form the nine partial products.
module vpa_front #(
    parameter int SAMPLE_BITS = vpa_pkg::SAMPLE_BITS_DEF
) (
    input  logic signed [SAMPLE_BITS-1:0] thigh_x,
    input  logic signed [SAMPLE_BITS-1:0] thigh_y,
    input  logic signed [SAMPLE_BITS-1:0] thigh_z,
    input  logic signed [SAMPLE_BITS-1:0] shank_x,
    input  logic signed [SAMPLE_BITS-1:0] shank_y,
    input  logic signed [SAMPLE_BITS-1:0] shank_z,
    output vpa_pkg::vpa_prod_t            prod
);
    import vpa_pkg::*;

    localparam int PW = 2 * SAMPLE_BITS;

    logic signed [PW-1:0] p_axbx, p_ayby, p_azbz;
    logic signed [PW-1:0] p_aybz, p_azby, p_azbx, p_axbz, p_axby, p_aybx;

    assign p_axbx = thigh_x * shank_x;
    assign p_ayby = thigh_y * shank_y;
    assign p_azbz = thigh_z * shank_z;
    assign p_aybz = thigh_y * shank_z;
    assign p_azby = thigh_z * shank_y;
    assign p_azbx = thigh_z * shank_x;
    assign p_axbz = thigh_x * shank_z;
    assign p_axby = thigh_x * shank_y;
    assign p_aybx = thigh_y * shank_x;

    always_comb
    begin
        prod.nz   = (|{thigh_x, thigh_y, thigh_z}) && (|{shank_x, shank_y, shank_z});
        prod.axbx = PROD_W'(p_axbx);
        prod.ayby = PROD_W'(p_ayby);
        prod.azbz = PROD_W'(p_azbz);
        prod.aybz = PROD_W'(p_aybz);
        prod.azby = PROD_W'(p_azby);
        prod.azbx = PROD_W'(p_azbx);
        prod.axbz = PROD_W'(p_axbz);
        prod.axby = PROD_W'(p_axby);
        prod.aybx = PROD_W'(p_aybx);
    end

endmodule

// ----- rtl/vpa_queue.sv -----
// Short register queue between the front and back parts.
module vpa_queue #(
    parameter int WIDTH = vpa_pkg::PROD_BEAT_W,
    parameter int DEPTH = vpa_pkg::QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [WIDTH-1:0]       push_data,
    input  logic                   pop,
    output logic [WIDTH-1:0]       pop_data,
    output vpa_pkg::vpa_qstat_t    stat
);
    import vpa_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/vpa_back.sv -----
// Back part: dot and cross sums, prescale, square root, normalize, CORDIC, round.
module vpa_back #(
    parameter int ANGLE_FRAC_BITS = vpa_pkg::ANGLE_FRAC_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  vpa_pkg::vpa_prod_t              prod,
    output logic                            done,
    output logic [vpa_pkg::ANGLE_BITS-1:0]  angle,
    output logic                            angle_valid
);
    import vpa_pkg::*;

    localparam int          OUT_SHIFT = ANG_UNIT_BITS - ANGLE_FRAC_BITS;
    localparam logic [63:0] HALF_STEP = 64'd1 << (OUT_SHIFT - 1);
    localparam logic [63:0] PRE_LIM   = 64'd1 << 31;

    // sums
    logic               v1_reg, ok1_reg;
    logic signed [63:0] dot1_reg, cx1_reg, cy1_reg, cz1_reg;
    // magnitudes
    logic               v2_reg, ok2_reg, dneg2_reg;
    logic [63:0]        dm2_reg, mx2_reg, my2_reg, mz2_reg;
    // max
    logic               v3_reg, ok3_reg, dneg3_reg;
    logic [63:0]        dm3_reg, mx3_reg, my3_reg, mz3_reg, m3_reg;
    // shift select
    logic               v4_reg, ok4_reg, dneg4_reg;
    logic [63:0]        dm4_reg, mx4_reg, my4_reg, mz4_reg;
    logic [PRE_W-1:0]   s4_reg;
    logic [PRE_W-1:0]   s_sel;
    // shift apply
    logic               v5_reg, ok5_reg, dneg5_reg;
    logic [63:0]        dm5_reg;
    logic [31:0]        mx5_reg, my5_reg, mz5_reg;
    // squares
    logic               v6_reg, ok6_reg, dneg6_reg;
    logic [63:0]        dm6_reg, qx6_reg, qy6_reg, qz6_reg;

    // square root pipe, index 0 is the sum of squares
    logic               sv_reg   [SQRT_STEPS+1];
    logic               sok_reg  [SQRT_STEPS+1];
    logic               sdn_reg  [SQRT_STEPS+1];
    logic [63:0]        sdm_reg  [SQRT_STEPS+1];
    logic [63:0]        sn_reg   [SQRT_STEPS+1];
    logic [63:0]        sr_reg   [SQRT_STEPS+1];

    // normalize pipe, index 0 is the CORDIC set-up
    logic               nv_reg   [NORM_STEPS+1];
    logic               nok_reg  [NORM_STEPS+1];
    logic [63:0]        nx_reg   [NORM_STEPS+1];
    logic [63:0]        ny_reg   [NORM_STEPS+1];
    logic [63:0]        nt_reg   [NORM_STEPS+1];
    logic signed [63:0] nz_reg   [NORM_STEPS+1];

    // CORDIC pipe, index 0 is the normalized vector
    logic               cv_reg   [CORDIC_ITERS+1];
    logic               cok_reg  [CORDIC_ITERS+1];
    logic signed [63:0] cxr_reg  [CORDIC_ITERS+1];
    logic signed [63:0] cyr_reg  [CORDIC_ITERS+1];
    logic signed [63:0] czr_reg  [CORDIC_ITERS+1];

    logic               done_reg, valid_out_reg;
    logic [ANGLE_BITS-1:0] angle_reg;
    logic [63:0]        r_clamp, r_round;
    logic signed [63:0] z_fin;
    logic [63:0]        x_set, y_set;

    always_comb
    begin
        s_sel = PRE_W'(PRE_MAX);
        for (int s = PRE_MAX; s >= 0; s--)
        begin
            if ((m3_reg >> s) <= PRE_LIM)
            begin
                s_sel = PRE_W'(s);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            sv_reg[0] <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            sv_reg[0] <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ok1_reg  <= prod.nz;
        dot1_reg <= 64'(prod.axbx) + 64'(prod.ayby) + 64'(prod.azbz);
        cx1_reg  <= 64'(prod.aybz) - 64'(prod.azby);
        cy1_reg  <= 64'(prod.azbx) - 64'(prod.axbz);
        cz1_reg  <= 64'(prod.axby) - 64'(prod.aybx);

        ok2_reg   <= ok1_reg;
        dneg2_reg <= dot1_reg < 0;
        dm2_reg   <= (dot1_reg < 0) ? 64'(-dot1_reg) : 64'(dot1_reg);
        mx2_reg   <= (cx1_reg < 0) ? 64'(-cx1_reg) : 64'(cx1_reg);
        my2_reg   <= (cy1_reg < 0) ? 64'(-cy1_reg) : 64'(cy1_reg);
        mz2_reg   <= (cz1_reg < 0) ? 64'(-cz1_reg) : 64'(cz1_reg);

        ok3_reg   <= ok2_reg;
        dneg3_reg <= dneg2_reg;
        dm3_reg   <= dm2_reg;
        mx3_reg   <= mx2_reg;
        my3_reg   <= my2_reg;
        mz3_reg   <= mz2_reg;
        if (mx2_reg >= my2_reg && mx2_reg >= mz2_reg)
        begin
            m3_reg <= mx2_reg;
        end
        else if (my2_reg >= mz2_reg)
        begin
            m3_reg <= my2_reg;
        end
        else
        begin
            m3_reg <= mz2_reg;
        end

        ok4_reg   <= ok3_reg;
        dneg4_reg <= dneg3_reg;
        dm4_reg   <= dm3_reg;
        mx4_reg   <= mx3_reg;
        my4_reg   <= my3_reg;
        mz4_reg   <= mz3_reg;
        s4_reg    <= s_sel;

        ok5_reg   <= ok4_reg;
        dneg5_reg <= dneg4_reg;
        dm5_reg   <= dm4_reg >> s4_reg;
        mx5_reg   <= 32'(mx4_reg >> s4_reg);
        my5_reg   <= 32'(my4_reg >> s4_reg);
        mz5_reg   <= 32'(mz4_reg >> s4_reg);

        ok6_reg   <= ok5_reg;
        dneg6_reg <= dneg5_reg;
        dm6_reg   <= dm5_reg;
        qx6_reg   <= 64'(mx5_reg) * 64'(mx5_reg);
        qy6_reg   <= 64'(my5_reg) * 64'(my5_reg);
        qz6_reg   <= 64'(mz5_reg) * 64'(mz5_reg);

        sok_reg[0] <= ok6_reg;
        sdn_reg[0] <= dneg6_reg;
        sdm_reg[0] <= dm6_reg;
        sn_reg[0]  <= qx6_reg + qy6_reg + qz6_reg;
        sr_reg[0]  <= 64'd0;
    end

    genvar j;
    generate
        for (j = 0; j < SQRT_STEPS; j++)
        begin : g_sqrt
            localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
            logic [63:0] trial;
            assign trial = sr_reg[j] + BIT;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sv_reg[j+1] <= 1'b0;
                end
                else
                begin
                    sv_reg[j+1] <= sv_reg[j];
                end
            end

            always_ff @(posedge clk)
            begin
                sok_reg[j+1] <= sok_reg[j];
                sdn_reg[j+1] <= sdn_reg[j];
                sdm_reg[j+1] <= sdm_reg[j];
                if (sn_reg[j] >= trial)
                begin
                    sn_reg[j+1] <= sn_reg[j] - trial;
                    sr_reg[j+1] <= (sr_reg[j] >> 1) + BIT;
                end
                else
                begin
                    sn_reg[j+1] <= sn_reg[j];
                    sr_reg[j+1] <= sr_reg[j] >> 1;
                end
            end
        end
    endgenerate

    assign x_set = sdn_reg[SQRT_STEPS] ? sr_reg[SQRT_STEPS] : sdm_reg[SQRT_STEPS];
    assign y_set = sdn_reg[SQRT_STEPS] ? sdm_reg[SQRT_STEPS] : sr_reg[SQRT_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nv_reg[0] <= 1'b0;
        end
        else
        begin
            nv_reg[0] <= sv_reg[SQRT_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        nx_reg[0]  <= x_set;
        ny_reg[0]  <= y_set;
        nt_reg[0]  <= (x_set > y_set) ? x_set : y_set;
        nok_reg[0] <= sok_reg[SQRT_STEPS] && ((x_set | y_set) != 64'd0);
        nz_reg[0]  <= sdn_reg[SQRT_STEPS] ? signed'(HALF_PI_Q48) : 64'sd0;
    end

    genvar k;
    generate
        for (k = 0; k < NORM_STEPS; k++)
        begin : g_norm
            localparam int SH = 1 << (NORM_STEPS - 1 - k);
            logic low;
            assign low = (nt_reg[k] >> (NORM_BIT + 1 - SH)) == 64'd0;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    nv_reg[k+1] <= 1'b0;
                end
                else
                begin
                    nv_reg[k+1] <= nv_reg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                nok_reg[k+1] <= nok_reg[k];
                nz_reg[k+1]  <= nz_reg[k];
                nx_reg[k+1]  <= low ? nx_reg[k] << SH : nx_reg[k];
                ny_reg[k+1]  <= low ? ny_reg[k] << SH : ny_reg[k];
                nt_reg[k+1]  <= low ? nt_reg[k] << SH : nt_reg[k];
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg[0] <= 1'b0;
        end
        else
        begin
            cv_reg[0] <= nv_reg[NORM_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        cok_reg[0] <= nok_reg[NORM_STEPS];
        cxr_reg[0] <= signed'(nx_reg[NORM_STEPS]);
        cyr_reg[0] <= signed'(ny_reg[NORM_STEPS]);
        czr_reg[0] <= nz_reg[NORM_STEPS];
    end

    genvar i;
    generate
        for (i = 0; i < CORDIC_ITERS; i++)
        begin : g_cordic
            localparam logic signed [63:0] ATAN = signed'(atan_entry(i));
            logic signed [63:0] xs, ys;
            assign xs = cxr_reg[i] >>> i;
            assign ys = cyr_reg[i] >>> i;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    cv_reg[i+1] <= 1'b0;
                end
                else
                begin
                    cv_reg[i+1] <= cv_reg[i];
                end
            end

            always_ff @(posedge clk)
            begin
                cok_reg[i+1] <= cok_reg[i];
                if (cyr_reg[i] >= 0)
                begin
                    cxr_reg[i+1] <= cxr_reg[i] + ys;
                    cyr_reg[i+1] <= cyr_reg[i] - xs;
                    czr_reg[i+1] <= czr_reg[i] + ATAN;
                end
                else
                begin
                    cxr_reg[i+1] <= cxr_reg[i] - ys;
                    cyr_reg[i+1] <= cyr_reg[i] + xs;
                    czr_reg[i+1] <= czr_reg[i] - ATAN;
                end
            end
        end
    endgenerate

    assign z_fin = czr_reg[CORDIC_ITERS];

    always_comb
    begin
        if (z_fin < 0)
        begin
            r_clamp = 64'd0;
        end
        else if (64'(z_fin) > PI_Q48)
        begin
            r_clamp = PI_Q48;
        end
        else
        begin
            r_clamp = 64'(z_fin);
        end
        r_round = (r_clamp + HALF_STEP) >> OUT_SHIFT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cv_reg[CORDIC_ITERS];
        end
    end

    always_ff @(posedge clk)
    begin
        valid_out_reg <= cok_reg[CORDIC_ITERS];
        angle_reg     <= cok_reg[CORDIC_ITERS] ? ANGLE_BITS'(r_round) : '0;
    end

    assign done        = done_reg;
    assign angle       = angle_reg;
    assign angle_valid = valid_out_reg;

endmodule

// ----- rtl/vector_pair_angle.sv -----
// Top level of the vector pair angle block: front, queue and back parts.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------------
//  sample   | start, busy        | thigh_x/y/z, shank_x/y/z (signed SAMPLE_BITS)
//  result   | done (one cycle)   | angle (15 bit rad, ANGLE_FRAC_BITS frac), angle_valid
//
//  One beat per cycle; each result leaves in the order of its start beat, after passing the
//  queue, the 32-step square root and the 40-iteration CORDIC pipelines.
//  busy is the queue-full flag; the back part drains one beat per cycle so it stays low.
//  Reset clears the queue pointers and every stage valid bit; no clearing pass.
//  done is a strobe: the receiver takes each result in the cycle it appears.
module vector_pair_angle #(
    parameter int SAMPLE_BITS     = vpa_pkg::SAMPLE_BITS_DEF,
    parameter int ANGLE_FRAC_BITS = vpa_pkg::ANGLE_FRAC_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [SAMPLE_BITS-1:0]   thigh_x,
    input  logic signed [SAMPLE_BITS-1:0]   thigh_y,
    input  logic signed [SAMPLE_BITS-1:0]   thigh_z,
    input  logic signed [SAMPLE_BITS-1:0]   shank_x,
    input  logic signed [SAMPLE_BITS-1:0]   shank_y,
    input  logic signed [SAMPLE_BITS-1:0]   shank_z,
    output logic                            done,
    output logic [vpa_pkg::ANGLE_BITS-1:0]  angle,
    output logic                            angle_valid
);
    import vpa_pkg::*;

    vpa_prod_t  prod_in, prod_out;
    vpa_qstat_t qstat;
    logic [PROD_BEAT_W-1:0] q_data;

    vpa_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .thigh_x (thigh_x),
        .thigh_y (thigh_y),
        .thigh_z (thigh_z),
        .shank_x (shank_x),
        .shank_y (shank_y),
        .shank_z (shank_z),
        .prod    (prod_in)
    );

    vpa_queue #(.WIDTH(PROD_BEAT_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (start),
        .push_data (prod_in),
        .pop       (1'b1),
        .pop_data  (q_data),
        .stat      (qstat)
    );

    assign prod_out = q_data;
    assign busy     = qstat.full;

    vpa_back #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (!qstat.empty),
        .prod        (prod_out),
        .done        (done),
        .angle       (angle),
        .angle_valid (angle_valid)
    );

endmodule

// ----- rtl/vpa_checker.sv -----
// Port-level checker for the vector pair angle block, bound to the top level.
module vpa_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            done,
    input logic [vpa_pkg::ANGLE_BITS-1:0]  angle,
    input logic                            angle_valid
);
    import vpa_pkg::*;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("result beat missing at fixed latency");

    a_no_stray: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result beat without matching start beat");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("queue filled although back part drains every cycle");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !angle_valid |-> angle == '0)
        else $error("invalid result carries nonzero angle");

endmodule

bind vector_pair_angle vpa_checker u_vpa_checker (.*);
